/* design/bmpw_pkg.sv */
// Package for the BMP to RGB565 display writer: constants, types and codes.
// No dependencies.
`default_nettype none
package bmpw_pkg;
    localparam int PanelWidthDefault  = 176;
    localparam int PanelHeightDefault = 220;
    localparam logic [7:0] CmdColWin = 8'h23;
    localparam logic [7:0] CmdRowWin = 8'h24;
    localparam logic [7:0] CmdColAdr = 8'h21;
    localparam logic [7:0] CmdRowAdr = 8'h22;
    localparam logic [10:0] MaxWidth = 11'd1280;
    localparam logic [5:0] HeaderLen = 6'd34;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2,
        KIND_REJ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_FLIP = 2'd0,
        REG_COL  = 2'd1,
        REG_ROW  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_GAP, PH_SKIP, PH_DRAW, PH_DONE
    } phase_t;

    // Job handed from the parser to the emitter for one byte.
    typedef struct packed {
        logic        window;  // emit the seven window writes first
        logic [7:0]  cs;
        logic [7:0]  ce;
        logic [7:0]  row;
        logic        pixel;   // emit one pixel word
        logic [15:0] pix;
        logic        done;    // emit image finished
        logic        rej;     // emit file rejected
    } job_t;
endpackage
`default_nettype wire

/* design/bmpw_stream_if.sv */
// Valid/ready channel interface with a generic payload.
// No dependencies.
`default_nettype none
interface bmpw_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/bmpw_parser.sv */
// Front end: parses the BMP byte stream and turns each byte into an emit job.
// Depends on bmpw_pkg.
`default_nettype none
module bmpw_parser #(
    parameter int PANEL_WIDTH  = bmpw_pkg::PanelWidthDefault,
    parameter int PANEL_HEIGHT = bmpw_pkg::PanelHeightDefault
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic [7:0]       data_byte,
    input  wire logic             first_byte,
    input  wire logic             flip_vertical,
    input  wire logic [7:0]       column_offset,
    input  wire logic [7:0]       row_offset,
    output bmpw_pkg::job_t        job,
    output logic                  job_any
);
    import bmpw_pkg::*;

    localparam logic [31:0] PW = 32'(PANEL_WIDTH);
    localparam logic [31:0] PH = 32'(PANEL_HEIGHT);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] poff_reg, poff_next;
    logic [31:0] wid_reg, wid_next;
    logic [31:0] hgt_reg, hgt_next;
    logic        ok_reg, ok_next;
    logic [31:0] skip_reg, skip_next;
    logic [11:0] bir_reg, bir_next;
    logic [7:0]  row_reg, row_next;
    logic [1:0]  cph_reg, cph_next;
    logic [15:0] part_reg, part_next;
    logic [7:0]  x0_reg, x0_next, x1_reg, x1_next, y0_reg, y0_next, y1_reg, y1_next;
    // Derived per-image row sizes, registered at header end.
    logic [11:0] rowb_reg, rowb_next;
    logic [11:0] vis3_reg, vis3_next;

    phase_t      ph;
    logic [31:0] pos;
    logic [31:0] pos1;
    logic [1:0]  bsel;
    logic [11:0] bir1;
    logic        bad;
    logic [15:0] pix;
    logic [31:0] half_w, half_h;
    logic [10:0] w11;
    logic [12:0] rb13;

    // Next-state logic for the parser.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;  poff_next = poff_reg;
        wid_next = wid_reg;  hgt_next = hgt_reg;  ok_next = ok_reg;
        skip_next = skip_reg; bir_next = bir_reg; row_next = row_reg;
        cph_next = cph_reg;  part_next = part_reg;
        x0_next = x0_reg; x1_next = x1_reg; y0_next = y0_reg; y1_next = y1_reg;
        rowb_next = rowb_reg; vis3_next = vis3_reg;
        job = '0;
        ph = phase_reg;
        pos = pos_reg;
        pos1 = '0;
        bsel = '0;
        pix = '0;
        bad = 1'b0;
        half_w = (PW - wid_reg) >> 1;
        half_h = (PH - hgt_reg) >> 1;
        w11 = wid_reg[10:0];
        rb13 = 13'((({2'b0, w11} * 13'd3) + 13'd3) & ~13'd3);
        bir1 = bir_reg + 12'd1;
        job.cs = column_offset + x0_reg;
        job.ce = column_offset + x1_reg;
        job.row = flip_vertical ? (row_offset - row_reg) : (row_offset + row_reg);
        if (in_fire) begin
            if (first_byte) begin
                pos = '0;
                ph = PH_HEADER;
                poff_next = '0; wid_next = '0; hgt_next = '0; ok_next = 1'b1;
                phase_next = PH_HEADER;
            end
            pos1 = pos + 32'd1;
            // Byte lane of a little-endian header field; every field starts at 2 mod 4.
            bsel = pos[1:0] - 2'd2;
            unique case (ph)
                PH_HEADER:
                begin
                    pos_next = pos1;
                    case (pos[5:0])
                        6'd10, 6'd11, 6'd12, 6'd13:
                            poff_next[8*bsel +: 8] = data_byte;
                        6'd18, 6'd19, 6'd20, 6'd21:
                            wid_next[8*bsel +: 8] = data_byte;
                        6'd22, 6'd23, 6'd24, 6'd25:
                            hgt_next[8*bsel +: 8] = data_byte;
                        6'd26: if (data_byte != 8'd1) ok_next = 1'b0;
                        6'd28: if (data_byte != 8'd24) ok_next = 1'b0;
                        6'd27, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33:
                            if (data_byte != 8'd0) ok_next = 1'b0;
                        default: ;
                    endcase
                    if (pos1 == 32'(HeaderLen)) begin
                        bad = !ok_next || wid_reg == 0 || wid_reg > 32'(MaxWidth)
                              || hgt_reg == 0 || poff_reg < 32'(HeaderLen);
                        if (bad) begin
                            job.rej = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            rowb_next = rb13[11:0];
                            if (wid_reg > PW) begin
                                x0_next = 8'd0; x1_next = 8'(PW - 1);
                                vis3_next = 12'(PW * 3);
                            end else begin
                                x0_next = 8'(half_w);
                                x1_next = 8'(half_w + wid_reg - 1);
                                vis3_next = 12'(wid_reg * 3);
                            end
                            if (hgt_reg > PH) begin
                                y0_next = 8'd0; y1_next = 8'(PH - 1);
                                skip_next = hgt_reg - PH;
                            end else begin
                                y0_next = 8'(half_h);
                                y1_next = 8'(half_h + hgt_reg - 1);
                                skip_next = '0;
                            end
                            if (poff_reg == 32'(HeaderLen)) begin
                                bir_next = '0; cph_next = '0; part_next = '0;
                                row_next = y1_next;
                                phase_next = (skip_next != 0) ? PH_SKIP : PH_DRAW;
                            end else begin
                                phase_next = PH_GAP;
                            end
                        end
                    end
                end
                PH_GAP:
                begin
                    pos_next = pos1;
                    if (pos1 == poff_reg) begin
                        bir_next = '0; cph_next = '0; part_next = '0;
                        row_next = y1_reg;
                        phase_next = (skip_reg != 0) ? PH_SKIP : PH_DRAW;
                    end
                end
                PH_SKIP:
                begin
                    bir_next = bir1;
                    if (bir1 >= rowb_reg) begin
                        bir_next = '0;
                        skip_next = skip_reg - 32'd1;
                        if (skip_reg == 32'd1) phase_next = PH_DRAW;
                    end
                end
                PH_DRAW:
                begin
                    job.window = (bir_reg == 12'd0);
                    if (bir_reg < vis3_reg) begin
                        case (cph_reg)
                            2'd0:
                            begin
                                part_next = {11'd0, data_byte[7:3]};
                                cph_next = 2'd1;
                            end
                            2'd1:
                            begin
                                part_next = part_reg | {5'd0, data_byte[7:2], 5'd0};
                                cph_next = 2'd2;
                            end
                            default:
                            begin
                                pix = part_reg | {data_byte[7:3], 11'd0};
                                part_next = pix;
                                cph_next = 2'd0;
                                job.pixel = 1'b1;
                                job.pix = pix;
                                if (bir1 == vis3_reg && row_reg == y0_reg)
                                    job.done = 1'b1;
                            end
                        endcase
                    end
                    bir_next = bir1;
                    if (job.done) begin
                        phase_next = PH_DONE;
                    end else if (bir1 >= rowb_reg) begin
                        bir_next = '0;
                        cph_next = '0;
                        row_next = row_reg - 8'd1;
                    end
                end
                default: ;
            endcase
        end
        job_any = in_fire && (job.window || job.pixel || job.done || job.rej);
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            pos_reg <= '0; poff_reg <= '0; wid_reg <= '0; hgt_reg <= '0;
            ok_reg <= 1'b0; skip_reg <= '0; bir_reg <= '0; row_reg <= '0;
            cph_reg <= '0; part_reg <= '0;
            x0_reg <= '0; x1_reg <= '0; y0_reg <= '0; y1_reg <= '0;
            rowb_reg <= '0; vis3_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg <= pos_next; poff_reg <= poff_next;
            wid_reg <= wid_next; hgt_reg <= hgt_next; ok_reg <= ok_next;
            skip_reg <= skip_next; bir_reg <= bir_next; row_reg <= row_next;
            cph_reg <= cph_next; part_reg <= part_next;
            x0_reg <= x0_next; x1_reg <= x1_next; y0_reg <= y0_next; y1_reg <= y1_next;
            rowb_reg <= rowb_next; vis3_reg <= vis3_next;
        end
    end
endmodule
`default_nettype wire

/* design/bmpw_job_fifo.sv */
// Short queue of emit jobs between the parser and the emitter.
// Depends on bmpw_pkg.
`default_nettype none
module bmpw_job_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  bmpw_pkg::job_t      push_job,
    input  wire logic           pop,
    output bmpw_pkg::job_t      head,
    output logic                not_empty,
    output logic                has_room
);
    import bmpw_pkg::*;

    job_t        mem_reg [4];
    logic [1:0]  wr_reg, rd_reg;
    logic [2:0]  cnt_reg;

    assign head = mem_reg[rd_reg];
    assign not_empty = cnt_reg != 3'd0;
    // Room while fewer than four jobs are held.
    assign has_room = cnt_reg != 3'd4;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_job;
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule
`default_nettype wire

/* design/bmpw_emitter.sv */
// Back end: expands one job into its sequence of result transactions.
// Depends on bmpw_pkg and bmpw_stream_if.
`default_nettype none
module bmpw_emitter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  bmpw_pkg::job_t      job,
    input  wire logic           job_valid,
    output logic                job_pop,
    bmpw_stream_if.source       res
);
    import bmpw_pkg::*;

    // Step through the job: 0..6 window writes, 7 pixel, 8 done/reject.
    logic [3:0]  step_reg, step_next;
    logic [3:0]  start, stop;
    logic [3:0]  s;
    kind_t       kind;
    logic [15:0] word;
    logic        fire;

    always_comb
    begin
        start = job.window ? 4'd0 : (job.pixel ? 4'd7 : 4'd8);
        stop  = (job.done || job.rej) ? 4'd8 : (job.pixel ? 4'd7 : 4'd6);
        s = (step_reg == 4'd0) ? start : step_reg;
        kind = KIND_CMD;
        word = '0;
        case (s)
            4'd0: word = {8'd0, CmdColWin};
            4'd1: begin kind = KIND_DATA; word = {job.ce, job.cs}; end
            4'd2: word = {8'd0, CmdRowWin};
            4'd3: begin kind = KIND_DATA; word = {job.row, job.row}; end
            4'd4: word = {8'd0, CmdColAdr};
            4'd5: begin kind = KIND_DATA; word = {job.row, job.cs}; end
            4'd6: word = {8'd0, CmdRowAdr};
            4'd7: begin kind = KIND_DATA; word = job.pix; end
            default: kind = job.rej ? KIND_REJ : KIND_DONE;
        endcase
        res.valid = job_valid;
        res.data = {kind, word, s == stop};
        fire = job_valid && res.ready;
        job_pop = fire && (s == stop);
        step_next = step_reg;
        if (fire) begin
            step_next = (s == stop) ? 4'd0 :
                        ((s == 4'd6 && !job.pixel) ? 4'd8 : s + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) step_reg <= '0;
        else step_reg <= step_next;
    end
endmodule
`default_nettype wire

/* design/bmp24_to_rgb565_display_writer.sv */
// Top level of the 24-bit BMP to RGB565 display writer.
// Depends on bmpw_pkg, bmpw_stream_if, bmpw_parser, bmpw_job_fifo, bmpw_emitter.
//
// Takes one file byte per cycle (in.data = {data_byte, first_byte}) and emits
// results as out.data = {kind, word, last}. The parser handles one byte per
// cycle and queues at most one job per byte into a four-entry queue; the emitter
// drains one result per cycle. The first byte of each drawn row yields seven
// results (the window writes), the third byte of each visible pixel yields its
// pixel word, the final pixel of the image adds the finished marker, and the
// last header byte of a rejected file yields one reject result; every other
// byte yields nothing. Input is accepted whenever the queue has room, so bytes
// flow at one per cycle and the input only stalls when the output side holds
// off or row starts arrive faster than their seven results drain.
`default_nettype none
module bmp24_to_rgb565_display_writer #(
    parameter int PANEL_WIDTH  = bmpw_pkg::PanelWidthDefault,
    parameter int PANEL_HEIGHT = bmpw_pkg::PanelHeightDefault
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    bmpw_stream_if.sink     in,
    bmpw_stream_if.source   out,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import bmpw_pkg::*;

    logic       flip_reg;
    logic [7:0] col_reg, row_reg;
    job_t       pjob, head;
    logic       pany, not_empty, has_room, pop, in_fire;

    assign in.ready = has_room;
    assign in_fire = in.valid && in.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flip_reg <= 1'b0; col_reg <= '0; row_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_FLIP: flip_reg <= cfg_data[0];
                REG_COL:  col_reg <= cfg_data;
                REG_ROW:  row_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bmpw_parser #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_parser (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .data_byte(in.data[8:1]), .first_byte(in.data[0]),
        .flip_vertical(flip_reg), .column_offset(col_reg), .row_offset(row_reg),
        .job(pjob), .job_any(pany)
    );

    bmpw_job_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(pany), .push_job(pjob),
        .pop(pop), .head(head), .not_empty(not_empty), .has_room(has_room)
    );

    bmpw_emitter u_emit (
        .clk(clk), .rst_n(rst_n), .job(head), .job_valid(not_empty),
        .job_pop(pop), .res(out)
    );

    // Jobs are never pushed without an accepted byte.
    a_push_fire: assert property (@(posedge clk) disable iff (!rst_n)
        pany |-> in_fire) else $error("job pushed without input");
    // A result is offered only when a job is queued.
    a_out_job: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> not_empty) else $error("result without job");
    // A pop happens only on a completed last result.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (out.valid && out.ready && out.data[0])) else $error("bad pop");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the BMP to RGB565 display writer.
// Depends on bmpw_pkg, bmpw_stream_if and bmp24_to_rgb565_display_writer.
// Streams whole bitmap files and checks every result against a predictor.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bmpw_pkg::*;

    localparam int PanelW = PanelWidthDefault;
    localparam int PanelH = PanelHeightDefault;
    localparam int SettleCycles = 40;
    localparam int RandBytesPerPass = 30;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] word;
        logic        last;
    } result_t;

    // One file byte waiting to be sent.
    typedef struct {
        logic [7:0] b;
        logic       first;
        logic       pause;    // hold this byte until all results are back
        logic       chk_rej;  // this byte must reject the file
    } file_byte_t;

    // One directed file: header fields, cut length (0 for whole), stray bytes.
    typedef struct {
        int unsigned w;
        int unsigned h;
        int unsigned off;
        int unsigned planes;
        int unsigned bpp;
        int unsigned comp;
        int          cut;
        int          strays;
        bit          rej;
    } file_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    bmpw_stream_if #(.W(9))  in_ch();
    bmpw_stream_if #(.W(19)) out_ch();

    bmp24_to_rgb565_display_writer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    file_byte_t byte_q[$];
    result_t    pending_q[$];
    int         mismatches;
    int         rand_bytes;
    bit         no_idle;
    bit         hold_req;

    // Predictor state, one copy of the block's registers and parser.
    logic        m_flip;
    logic [7:0]  m_col_ofs;
    logic [7:0]  m_row_ofs;
    logic [31:0] m_pos;
    logic [31:0] m_pix_off;
    logic [31:0] m_img_w;
    logic [31:0] m_img_h;
    logic        m_hdr_ok;
    phase_t      m_phase;
    logic [31:0] m_skip_rows;
    logic [31:0] m_row_byte;
    logic [7:0]  m_cur_row;
    logic [1:0]  m_color;
    logic [15:0] m_pix;
    logic [7:0]  m_win [4];
    result_t     step_res [8];
    int          step_n;

    // Small whole images, a cropped and a tall file cut short, and two rejects.
    file_row_t directed_rows [6] = '{
        '{1, 1, 34, 1, 24, 0, 0, 3, 0},
        '{2, 2, 40, 1, 24, 0, 0, 0, 0},
        '{177, 2, 54, 1, 24, 0, 60, 0, 0},
        '{1, 221, 34, 1, 24, 0, 46, 0, 0},
        '{2, 1, 34, 2, 24, 0, 34, 2, 1},
        '{1281, 1, 34, 1, 24, 0, 34, 0, 1}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic reset_predictor();
        m_flip = 1'b0;
        m_col_ofs = '0;
        m_row_ofs = '0;
        m_pos = '0;
        m_pix_off = '0;
        m_img_w = '0;
        m_img_h = '0;
        m_hdr_ok = 1'b0;
        m_phase = PH_IDLE;
        m_skip_rows = '0;
        m_row_byte = '0;
        m_cur_row = '0;
        m_color = '0;
        m_pix = '0;
        for (int i = 0; i < 4; i++)
        begin
            m_win[i] = '0;
        end
    endtask

    task automatic add_result(input kind_t k, input logic [15:0] w);
        step_res[step_n] = '{kind: k, word: w, last: 1'b0};
        step_n++;
    endtask

    task automatic start_pixels();
        m_row_byte = '0;
        m_color = '0;
        m_pix = '0;
        m_cur_row = m_win[3];
        m_phase = (m_skip_rows != 0) ? PH_SKIP : PH_DRAW;
    endtask

    task automatic add_window();
        logic [7:0] cs;
        logic [7:0] ce;
        logic [7:0] r;
        cs = m_col_ofs + m_win[0];
        ce = m_col_ofs + m_win[1];
        r = m_flip ? m_row_ofs - m_cur_row : m_row_ofs + m_cur_row;
        add_result(KIND_CMD, {8'h00, CmdColWin});
        add_result(KIND_DATA, {ce, cs});
        add_result(KIND_CMD, {8'h00, CmdRowWin});
        add_result(KIND_DATA, {r, r});
        add_result(KIND_CMD, {8'h00, CmdColAdr});
        add_result(KIND_DATA, {r, cs});
        add_result(KIND_CMD, {8'h00, CmdRowAdr});
    endtask

    // Checks the parsed header and sets up the centered or cropped window.
    task automatic close_header();
        if (!m_hdr_ok || m_img_w == 0 || m_img_w > MaxWidth || m_img_h == 0
            || m_pix_off < HeaderLen)
        begin
            add_result(KIND_REJ, '0);
            m_phase = PH_IDLE;
            return;
        end
        if (m_img_w > PanelW)
        begin
            m_win[0] = 8'd0;
            m_win[1] = 8'(PanelW - 1);
        end
        else
        begin
            m_win[0] = 8'((PanelW - m_img_w) / 2);
            m_win[1] = 8'(m_win[0] + m_img_w - 1);
        end
        if (m_img_h > PanelH)
        begin
            m_win[2] = 8'd0;
            m_win[3] = 8'(PanelH - 1);
            m_skip_rows = m_img_h - PanelH;
        end
        else
        begin
            m_win[2] = 8'((PanelH - m_img_h) / 2);
            m_win[3] = 8'(m_win[2] + m_img_h - 1);
            m_skip_rows = '0;
        end
        if (m_pix_off == HeaderLen)
            start_pixels();
        else
            m_phase = PH_GAP;
    endtask

    // Works out the results that one file byte causes and queues them.
    task automatic predict_byte(input logic [7:0] b, input logic first, output int n);
        logic [31:0] rb;
        logic [31:0] vis;
        logic [31:0] p;
        logic        fin;
        step_n = 0;
        if (first)
        begin
            m_pos = '0;
            m_pix_off = '0;
            m_img_w = '0;
            m_img_h = '0;
            m_hdr_ok = 1'b1;
            m_phase = PH_HEADER;
        end
        rb = ((m_img_w * 3) + 3) & ~32'd3;
        vis = (m_img_w > PanelW) ? PanelW : m_img_w;
        p = m_pos;
        case (m_phase)
            PH_HEADER:
            begin
                if (p >= 10 && p <= 13)
                    m_pix_off |= {24'd0, b} << (8 * (p - 10));
                else if (p >= 18 && p <= 21)
                    m_img_w |= {24'd0, b} << (8 * (p - 18));
                else if (p >= 22 && p <= 25)
                    m_img_h |= {24'd0, b} << (8 * (p - 22));
                else if (p == 26 && b != 8'd1)
                    m_hdr_ok = 1'b0;
                else if (p == 28 && b != 8'd24)
                    m_hdr_ok = 1'b0;
                else if ((p == 27 || (p >= 29 && p <= 33)) && b != 8'd0)
                    m_hdr_ok = 1'b0;
                m_pos++;
                if (m_pos == HeaderLen)
                    close_header();
            end
            PH_GAP:
            begin
                m_pos++;
                if (m_pos == m_pix_off)
                    start_pixels();
            end
            PH_SKIP:
            begin
                m_row_byte++;
                if (m_row_byte >= rb)
                begin
                    m_row_byte = '0;
                    m_skip_rows--;
                    if (m_skip_rows == 0)
                        m_phase = PH_DRAW;
                end
            end
            PH_DRAW:
            begin
                fin = 1'b0;
                if (m_row_byte == 0)
                    add_window();
                if (m_row_byte < 3 * vis)
                begin
                    if (m_color == 2'd0)
                    begin
                        m_pix = {11'd0, b[7:3]};
                        m_color = 2'd1;
                    end
                    else if (m_color == 2'd1)
                    begin
                        m_pix[10:5] = b[7:2];
                        m_color = 2'd2;
                    end
                    else
                    begin
                        m_pix[15:11] = b[7:3];
                        m_color = 2'd0;
                        add_result(KIND_DATA, m_pix);
                        if (m_row_byte == 3 * vis - 1 && m_cur_row == m_win[2])
                            fin = 1'b1;
                    end
                end
                m_row_byte++;
                if (fin)
                begin
                    add_result(KIND_DONE, '0);
                    m_phase = PH_DONE;
                end
                else if (m_row_byte >= rb)
                begin
                    m_row_byte = '0;
                    m_color = '0;
                    m_cur_row = m_cur_row - 8'd1;
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < step_n; i++)
        begin
            if (i == step_n - 1)
                step_res[i].last = 1'b1;
            pending_q.push_back(step_res[i]);
        end
        n = step_n;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_FLIP: m_flip = v[0];
            REG_COL:  m_col_ofs = v;
            default:  m_row_ofs = v;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic flip, input logic [7:0] col, input logic [7:0] row);
        write_reg(REG_FLIP, {7'd0, flip});
        write_reg(REG_COL, col);
        write_reg(REG_ROW, row);
    endtask

    // Waits until every byte is sent and every result is back, then lets the block drain.
    task automatic settle();
        while (byte_q.size() != 0 || in_ch.valid || pending_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Queues one bitmap file, cut short when cut is nonzero, then stray bytes.
    task automatic add_file(input int unsigned w, input int unsigned h, input int unsigned off,
                            input int unsigned planes, input int unsigned bpp,
                            input int unsigned comp, input int cut, input int strays,
                            input bit rej, input int pause_at);
        longint     total;
        logic [7:0] b;
        total = longint'(off) + longint'(((w * 3) + 3) & ~32'd3) * longint'(h);
        if (cut != 0)
            total = cut;
        for (int k = 0; k < total; k++)
        begin
            b = 8'($urandom);
            if (k == 0)
                b = 8'h42;
            else if (k == 1)
                b = 8'h4D;
            else if (k >= 10 && k <= 13)
                b = off[8 * (k - 10) +: 8];
            else if (k == 14)
                b = 8'd40;
            else if (k >= 18 && k <= 21)
                b = w[8 * (k - 18) +: 8];
            else if (k >= 22 && k <= 25)
                b = h[8 * (k - 22) +: 8];
            else if (k >= 26 && k <= 27)
                b = planes[8 * (k - 26) +: 8];
            else if (k >= 28 && k <= 29)
                b = bpp[8 * (k - 28) +: 8];
            else if (k >= 30 && k <= 33)
                b = comp[8 * (k - 30) +: 8];
            byte_q.push_back('{b, k == 0, k == pause_at, rej && k == 33});
        end
        for (int k = 0; k < strays; k++)
        begin
            byte_q.push_back('{8'($urandom), 1'b0, 1'b0, 1'b0});
        end
        rand_bytes += int'(total) + strays;
    endtask

    // Draws one random file: mostly small good images, some crops and tall ones
    // cut short, broken headers, cut files and noise.
    task automatic random_file();
        int unsigned w;
        int unsigned h;
        int unsigned off;
        int unsigned planes;
        int unsigned bpp;
        int unsigned comp;
        int          mode;
        int          cut;
        int          pause_at;
        int          bad;
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
        off = 34 + $urandom_range(0, 5);
        planes = 1;
        bpp = 24;
        comp = 0;
        cut = 0;
        mode = $urandom_range(0, 99);
        pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(34, 60) : -1;
        if (mode >= 70 && mode < 78)
        begin
            w = $urandom_range(170, 182);
            h = $urandom_range(1, 2);
            cut = 34 + $urandom_range(1, 40);
        end
        else if (mode >= 78 && mode < 83)
        begin
            w = $urandom_range(1, 3);
            h = $urandom_range(221, 223);
            off = 34;
            cut = 34 + $urandom_range(1, 30);
        end
        else if (mode >= 83 && mode < 91)
        begin
            bad = $urandom_range(0, 6);
            case (bad)
                0: planes = $urandom_range(0, 65535) | 32'h2;
                1: bpp = $urandom_range(25, 65535);
                2: comp = $urandom_range(1, 32'hFFFF_FFFF);
                3: w = 0;
                4: w = $urandom_range(1281, 32'hFFFF_FFFF);
                5: h = 0;
                default: off = $urandom_range(0, 33);
            endcase
            cut = 34;
        end
        else if (mode >= 91 && mode < 96)
        begin
            cut = $urandom_range(1, 60);
        end
        else if (mode >= 96)
        begin
            for (int k = 0; k < 20; k++)
            begin
                byte_q.push_back('{8'($urandom), 1'b0, 1'b0, 1'b0});
            end
            rand_bytes += 20;
            return;
        end
        add_file(w, h, off, planes, bpp, comp, cut, $urandom_range(0, 2), 1'b0, pause_at);
    endtask

    // Input side: predicts each accepted transaction and offers the next byte.
    initial
    begin
        file_byte_t cur;
        int         n;
        bit         idle;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        forever
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
            begin
                predict_byte(cur.b, cur.first, n);
                if (cur.chk_rej && (n != 1 || pending_q[$].kind != KIND_REJ))
                    report_mismatch("file not rejected", 32'(n), 32'd1);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                idle = !no_idle && $urandom_range(0, 99) < 27;
                if (byte_q.size() != 0 && !idle
                    && !(byte_q[0].pause && pending_q.size() != 0))
                begin
                    cur = byte_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data <= {cur.b, cur.first};
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each result transaction and applies back-pressure.
    initial
    begin
        result_t got;
        result_t want;
        int      hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = result_t'(out_ch.data);
                if (pending_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(got), 32'd0);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                    if (got.word != want.word)
                        report_mismatch("word", 32'(got.word), 32'(want.word));
                    if (got.last != want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end
            if (hold_req)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= no_idle || $urandom_range(0, 99) >= 27;
            end
        end
    end

    // Sequence: reset, directed files, then random files under several settings.
    initial
    begin
        file_row_t r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FLIP;
        cfg_data = '0;
        mismatches = 0;
        rand_bytes = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        reset_predictor();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(1'b0, 8'd0, 8'd0);

        // Stray bytes while idle, then the directed files.
        for (int k = 0; k < 3; k++)
        begin
            byte_q.push_back('{8'($urandom), 1'b0, 1'b0, 1'b0});
        end
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            add_file(r.w, r.h, r.off, r.planes, r.bpp, r.comp, r.cut, r.strays, r.rej,
                     (i == 1) ? 40 : -1);
        end
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_config(1'b1, 8'd255, 8'd255);
                1: set_config(1'b0, 8'd200, 8'd17);
                2: set_config(1'($urandom), 8'($urandom), 8'($urandom));
                default: set_config(1'b0, 8'd255, 8'd0);
            endcase
            no_idle = (ph == 2);
            rand_bytes = 0;
            if (ph == 1)
            begin
                add_file(4, 2, 34, 1, 24, 0, 0, 0, 1'b0, -1);
                hold_req = 1'b1;
            end
            while (rand_bytes < RandBytesPerPass)
                random_file();
            settle();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
